// ===== rtl/size_sorted_buffer_pool_top_macros.svh =====
// Assertion macros shared by the buffer pool RTL.
`ifndef SIZE_SORTED_BUFFER_POOL_TOP_MACROS_SVH
`define SIZE_SORTED_BUFFER_POOL_TOP_MACROS_SVH

// Check that cons holds in the cycle after ante.
`define SSBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("buffer pool check failed in the cycle after the trigger");

// Check that cons holds in the same cycle as ante.
`define SSBP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("buffer pool check failed in the trigger cycle");

`endif

// ===== rtl/ssbp_pkg.sv =====
// Types and constants of the size sorted buffer pool.
package ssbp_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int ID_W       = 8;
  localparam int CAP_W      = 16;
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic             command;
    logic [CAP_W-1:0] request_size;
    logic [ID_W-1:0]  buffer_id;
    logic [CAP_W-1:0] buffer_capacity;
  } ssbp_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ID_W-1:0]  granted_id;
    logic [CAP_W-1:0] granted_capacity;
  } ssbp_rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    logic             empty;
  } ssbp_stat_t;

endpackage

// ===== rtl/ssbp_list.sv =====
// Sorted free list: parallel compare, one-place shift insert and remove.
module ssbp_list import ssbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  ssbp_req_t  req_i,
  output ssbp_rsp_t  rsp_o,
  output ssbp_stat_t stat_o
);

  logic [ID_W-1:0]  ids_q  [POOL_DEPTH];
  logic [ID_W-1:0]  ids_d  [POOL_DEPTH];
  logic [CAP_W-1:0] caps_q [POOL_DEPTH];
  logic [CAP_W-1:0] caps_d [POOL_DEPTH];
  logic [CNT_W-1:0] count_q, count_d;

  logic [CAP_W-1:0]      key;
  logic [POOL_DEPTH-1:0] live, ge, fit, pos, first;
  logic                  full, hit, wr_en;
  logic [ID_W-1:0]       gnt_id;
  logic [CAP_W-1:0]      gnt_cap;

  assign key  = (req_i.command == CMD_RELEASE) ? req_i.buffer_capacity : req_i.request_size;
  assign full = (count_q == CNT_W'(POOL_DEPTH));

  // Entries are sorted, so ge and pos are thermometer codes.
  always_comb begin
    for (int i = 0; i < POOL_DEPTH; i++) begin
      live[i] = CNT_W'(i) < count_q;
      ge[i]   = caps_q[i] >= key;
      fit[i]  = live[i] && ge[i];
      pos[i]  = !live[i] || ge[i];
    end
  end

  always_comb begin
    first[0] = fit[0];
    for (int i = 1; i < POOL_DEPTH; i++) begin
      first[i] = fit[i] && !fit[i-1];
    end
  end

  assign hit = |fit;

  always_comb begin
    gnt_id  = '0;
    gnt_cap = '0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      gnt_id  = gnt_id  | (ids_q[i]  & {ID_W{first[i]}});
      gnt_cap = gnt_cap | (caps_q[i] & {CAP_W{first[i]}});
    end
  end

  always_comb begin
    for (int i = 0; i < POOL_DEPTH; i++) begin
      ids_d[i]  = ids_q[i];
      caps_d[i] = caps_q[i];
      if (req_i.command == CMD_RELEASE) begin
        if (pos[i]) begin
          if (i == 0) begin
            ids_d[i]  = req_i.buffer_id;
            caps_d[i] = req_i.buffer_capacity;
          end else if (!pos[i-1]) begin
            ids_d[i]  = req_i.buffer_id;
            caps_d[i] = req_i.buffer_capacity;
          end else begin
            ids_d[i]  = ids_q[i-1];
            caps_d[i] = caps_q[i-1];
          end
        end
      end else if (fit[i] && (i < POOL_DEPTH - 1)) begin
        // Close the gap left by the granted entry.
        ids_d[i]  = ids_q[i+1];
        caps_d[i] = caps_q[i+1];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    wr_en   = 1'b0;
    rsp_o   = '{status: ST_DONE, granted_id: '0, granted_capacity: '0};
    if (req_i.command == CMD_RELEASE) begin
      if (full) begin
        rsp_o.status = ST_FULL;
      end else begin
        wr_en   = valid_i;
        count_d = count_q + CNT_W'(1);
      end
    end else if (!hit) begin
      rsp_o.status = ST_NOFIT;
    end else begin
      wr_en                  = valid_i;
      count_d                = count_q - CNT_W'(1);
      rsp_o.granted_id       = gnt_id;
      rsp_o.granted_capacity = gnt_cap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (wr_en) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ids_q  <= ids_d;
      caps_q <= caps_d;
    end
  end

  assign stat_o = '{count: count_q, full: full, empty: (count_q == '0)};

endmodule

// ===== rtl/size_sorted_buffer_pool_top.sv =====
// Best-fit buffer pool: the request is registered in in_q, then the result in rsp_q.
// Throughput one item per cycle; busy stays low, the sorted register list
// handles one allocate or release per cycle through parallel compares.
// Each result shows for one cycle on rsp_o with rsp_valid_o; no stall.
// Reset empties the list and clears both valid flags; entry data is not reset.
`include "size_sorted_buffer_pool_top_macros.svh"
module size_sorted_buffer_pool_top import ssbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  ssbp_req_t req_i,
  output logic      rsp_valid_o,
  output ssbp_rsp_t rsp_o
);

  logic       in_valid_q;
  ssbp_req_t  in_q;
  logic       rsp_valid_q;
  ssbp_rsp_t  rsp_q, rsp_d;
  ssbp_stat_t stat;
  logic       accept;
  logic       rel_grow, rsp_fail, no_grant;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= accept;
      rsp_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= req_i;
    end
    if (in_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  ssbp_list u_list (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .req_i   (in_q),
    .rsp_o   (rsp_d),
    .stat_o  (stat)
  );

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assign rel_grow = in_valid_q && (in_q.command == CMD_RELEASE) && !stat.full;
  assign rsp_fail = rsp_valid_q && (rsp_q.status != ST_DONE);
  assign no_grant = (rsp_q.granted_id == '0) && (rsp_q.granted_capacity == '0);

  `SSBP_ASSERT_NEXT(a_rsp_follows_item, in_valid_q, rsp_valid_q)
  `SSBP_ASSERT_SAME(a_count_bounded, 1'b1, stat.count <= CNT_W'(POOL_DEPTH))
  `SSBP_ASSERT_NEXT(a_release_grows, rel_grow, stat.count == $past(stat.count) + CNT_W'(1))
  `SSBP_ASSERT_SAME(a_no_grant_on_fail, rsp_fail, no_grant)

endmodule
